/* hw/rtl/dlc_pkg.sv */
// Shared types and codes of the display list coprocessor.
package dlc_pkg;

   // Item commands
   localparam logic [2:0] CMD_START = 3'd0;
   localparam logic [2:0] CMD_WRITE = 3'd1;
   localparam logic [2:0] CMD_TICK  = 3'd2;
   localparam logic [2:0] CMD_WAKE  = 3'd3;
   localparam logic [2:0] CMD_DMA   = 3'd4;

   // Control word prefix and opcodes (word[11:8])
   localparam logic [3:0] PREFIX_CTRL = 4'hF;
   localparam logic [3:0] OP_SETA     = 4'h6;
   localparam logic [3:0] OP_WAITX    = 4'h7;
   localparam logic [3:0] OP_SETB_LO  = 4'h8;
   localparam logic [3:0] OP_SETB_HI  = 4'h9;
   localparam logic [3:0] OP_WAITY    = 4'hA;
   localparam logic [3:0] OP_WAIT     = 4'hB;
   localparam logic [3:0] OP_DJNZA    = 4'hC;
   localparam logic [3:0] OP_DJNZB    = 4'hD;
   localparam logic [3:0] OP_CALL     = 4'hE;
   localparam logic [3:0] OP_JUMP     = 4'hF;
   localparam logic [3:0] EV_FORM     = 4'hF;

   // Wait events and resume tags
   localparam logic [3:0] EV_DMA    = 4'd1;
   localparam logic [3:0] EV_FRAME  = 4'd2;
   localparam logic [3:0] EV_LINE   = 4'd3;
   localparam logic [7:0] TAG_NONE  = 8'h00;
   localparam logic [7:0] TAG_X     = 8'hF7;
   localparam logic [7:0] TAG_Y     = 8'hFA;

   localparam logic [7:0]  PORT_LOW      = 8'hAF;
   localparam logic [15:0] DMA_WAIT_WORD = 16'hFBF1;
   localparam logic [7:0]  X_LIMIT       = 8'd224;
   localparam logic [8:0]  Y_LIMIT       = 9'd320;
   localparam logic [15:0] CODE_X        = 16'h8000;
   localparam logic [15:0] CODE_Y        = 16'h4000;
   localparam logic [15:0] CODE_FRAME    = 16'h0000;
   localparam logic [15:0] CODE_LINE     = 16'hC000;
   localparam logic [7:0]  STOP_ADDR     = 8'hFF;
   localparam logic [7:0]  RETURN_TARGET = 8'hFF;

   typedef struct packed {
      logic [2:0] command;
      logic [8:0] byte_address;
      logic [7:0] byte_value;
      logic       dma_status;
   } item_type;

   typedef struct packed {
      logic        port_write_valid;
      logic [15:0] port_address;
      logic [7:0]  port_value;
      logic        wait_request_valid;
      logic [15:0] wait_code;
      logic        active;
      logic [7:0]  program_counter;
   } rsp_type;

endpackage

/* hw/rtl/dlc_req_if.sv */
// Request channel of the display list coprocessor.
interface dlc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [8:0] byte_address;
   logic [7:0] byte_value;
   logic       dma_status;

   modport source (output valid, command, byte_address, byte_value, dma_status,
                   input ready);
   modport sink (input valid, command, byte_address, byte_value, dma_status,
                 output ready);
endinterface

/* hw/rtl/dlc_rsp_if.sv */
// Response channel of the display list coprocessor.
interface dlc_rsp_if;
   logic        valid;
   logic        ready;
   logic        port_write_valid;
   logic [15:0] port_address;
   logic [7:0]  port_value;
   logic        wait_request_valid;
   logic [15:0] wait_code;
   logic        active;
   logic [7:0]  program_counter;

   modport source (output valid, port_write_valid, port_address, port_value,
                   wait_request_valid, wait_code, active, program_counter,
                   input ready);
   modport sink (input valid, port_write_valid, port_address, port_value,
                 wait_request_valid, wait_code, active, program_counter,
                 output ready);
endinterface

/* hw/rtl/display_list_coprocessor.sv */
// Display list coprocessor: runs a beam-synchronized program from a 256-word store
// that is loaded by byte writes. Every accepted item gives exactly one response item.
// An item is accepted at a clock edge, its instruction word comes out of the program store
// (two byte-wide synchronous RAMs) in the following cycle where it is executed, and
// the response is registered when the item commits. The next program counter
// is forwarded to the store's read address, so one item per cycle is sustained while
// the response side keeps up; a stalled response holds the executing item, and with
// it the request side, after one more item has been taken in.
module display_list_coprocessor import dlc_pkg::*; #(
   parameter int PROGRAM_WORDS = 256
) (
   input  logic      clock,
   input  logic      reset,
   dlc_req_if.sink   req,
   dlc_rsp_if.source rsp
);

   localparam int ADDR_W = $clog2(PROGRAM_WORDS);

   logic              req_accept;
   logic              exec_valid_ff;
   item_type          exec_item_ff;
   logic              commit;
   logic [7:0]        pc;
   rsp_type           exec_res;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_lo;
   logic              wr_hi;
   logic [7:0]        word_lo;
   logic [7:0]        word_hi;

   assign commit     = exec_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready  = !exec_valid_ff || commit;
   assign req_accept = req.valid && req.ready;

   // read the word at the pc the accepted item will see
   assign rd_addr = exec_valid_ff ? exec_res.program_counter[ADDR_W-1:0] : pc[ADDR_W-1:0];
   assign wr_addr = req.byte_address[ADDR_W:1];
   assign wr_lo   = req_accept && (req.command == CMD_WRITE) && !req.byte_address[0];
   assign wr_hi   = req_accept && (req.command == CMD_WRITE) && req.byte_address[0];

   dlc_ram #(.WIDTH(8), .DEPTH(PROGRAM_WORDS)) u_store_lo (
      .clock   (clock),
      .wr_en   (wr_lo),
      .wr_addr (wr_addr),
      .wr_data (req.byte_value),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (word_lo)
   );

   dlc_ram #(.WIDTH(8), .DEPTH(PROGRAM_WORDS)) u_store_hi (
      .clock   (clock),
      .wr_en   (wr_hi),
      .wr_addr (wr_addr),
      .wr_data (req.byte_value),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (word_hi)
   );

   dlc_exec u_exec (
      .clock  (clock),
      .reset  (reset),
      .item   (exec_item_ff),
      .word   ({word_hi, word_lo}),
      .commit (commit),
      .pc     (pc),
      .res    (exec_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            exec_valid_ff <= 1'b1;
         end else if (commit) begin
            exec_valid_ff <= 1'b0;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         exec_item_ff.command      <= req.command;
         exec_item_ff.byte_address <= req.byte_address;
         exec_item_ff.byte_value   <= req.byte_value;
         exec_item_ff.dma_status   <= req.dma_status;
      end
      if (commit) begin
         rsp_ff <= exec_res;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.port_write_valid   = rsp_ff.port_write_valid;
   assign rsp.port_address       = rsp_ff.port_address;
   assign rsp.port_value         = rsp_ff.port_value;
   assign rsp.wait_request_valid = rsp_ff.wait_request_valid;
   assign rsp.wait_code          = rsp_ff.wait_code;
   assign rsp.active             = rsp_ff.active;
   assign rsp.program_counter    = rsp_ff.program_counter;

endmodule

/* hw/rtl/dlc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/dlc_exec.sv */
// Instruction execute unit: sequencer registers and next-state logic.
module dlc_exec import dlc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  item_type    item,
   input  logic [15:0] word,
   input  logic        commit,
   output logic [7:0]  pc,
   output rsp_type     res
);

   logic       en_ff, en_in;
   logic       armed_ff, armed_in;
   logic [7:0] tag_ff, tag_in;
   logic [7:0] pc_ff, pc_in;
   logic [7:0] ret_ff, ret_in;
   logic [7:0] cnt_a_ff, cnt_a_in;
   logic [8:0] cnt_b_ff, cnt_b_in;

   logic       run;
   logic       arm_tick;
   logic [7:0] etag;
   logic [7:0] lo;
   logic [3:0] ev;
   logic [7:0] pc_next;
   logic [7:0] cnt_a_dec;
   logic [8:0] cnt_b_dec;

   assign lo        = word[7:0];
   assign ev        = word[3:0];
   assign pc_next   = pc_ff + 8'd1;
   assign cnt_a_dec = cnt_a_ff - 8'd1;
   assign cnt_b_dec = cnt_b_ff - 9'd1;

   always_comb begin
      en_in    = en_ff;
      armed_in = armed_ff;
      tag_in   = tag_ff;
      pc_in    = pc_ff;
      ret_in   = ret_ff;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      res      = '0;
      run      = 1'b0;
      arm_tick = 1'b1;
      etag     = TAG_NONE;

      case (item.command)
         CMD_START: begin
            en_in    = (item.byte_value != STOP_ADDR);
            armed_in = (item.byte_value != STOP_ADDR);
            tag_in   = TAG_NONE;
            pc_in    = item.byte_value;
         end
         CMD_TICK: begin
            run = armed_ff && (tag_ff == TAG_NONE);
         end
         CMD_WAKE: begin
            run  = armed_ff && (tag_ff != TAG_NONE);
            etag = tag_ff;
         end
         CMD_DMA: begin
            if (en_ff && item.dma_status && (word == DMA_WAIT_WORD)) begin
               pc_in    = pc_next;
               armed_in = 1'b1;
               tag_in   = TAG_NONE;
            end
         end
         default: begin
         end
      endcase

      if (run) begin
         if (word[15:12] != PREFIX_CTRL) begin
            res.port_write_valid = 1'b1;
            res.port_address     = {word[15:8], PORT_LOW};
            res.port_value       = lo;
            pc_in                = pc_next;
         end else begin
            case (word[11:8])
               OP_SETA: begin
                  cnt_a_in = lo;
                  pc_in    = pc_next;
               end
               OP_SETB_LO, OP_SETB_HI: begin
                  cnt_b_in = word[8:0];
                  pc_in    = pc_next;
               end
               OP_WAITX: begin
                  if (etag == TAG_X) begin
                     pc_in = pc_next;
                  end else begin
                     arm_tick = 1'b0;
                     if (lo < X_LIMIT) begin
                        res.wait_request_valid = 1'b1;
                        res.wait_code          = CODE_X | {8'h00, lo};
                        armed_in               = 1'b1;
                        tag_in                 = TAG_X;
                     end else begin
                        armed_in = 1'b0;
                        tag_in   = TAG_NONE;
                     end
                  end
               end
               OP_WAITY, OP_WAIT: begin
                  if ((word[11:8] == OP_WAIT) && (word[7:4] == EV_FORM)) begin
                     if ({4'h0, ev} == etag) begin
                        pc_in = pc_next;
                     end else if (ev == EV_DMA) begin
                        // parked until the dma ready item
                        arm_tick = 1'b0;
                        armed_in = 1'b0;
                        tag_in   = TAG_NONE;
                     end else if ((ev == EV_FRAME) || (ev == EV_LINE)) begin
                        arm_tick               = 1'b0;
                        res.wait_request_valid = 1'b1;
                        res.wait_code          = (ev == EV_FRAME) ? CODE_FRAME : CODE_LINE;
                        armed_in               = 1'b1;
                        tag_in                 = {4'h0, ev};
                     end else begin
                        pc_in = pc_next;
                     end
                  end else if (etag == TAG_Y) begin
                     pc_in = pc_next;
                  end else begin
                     arm_tick = 1'b0;
                     if (word[8:0] < Y_LIMIT) begin
                        res.wait_request_valid = 1'b1;
                        res.wait_code          = CODE_Y | {7'h00, word[8:0]};
                        armed_in               = 1'b1;
                        tag_in                 = TAG_Y;
                     end else begin
                        armed_in = 1'b0;
                        tag_in   = TAG_NONE;
                     end
                  end
               end
               OP_DJNZA: begin
                  cnt_a_in = cnt_a_dec;
                  pc_in    = (cnt_a_dec != 8'd0) ? lo : pc_next;
               end
               OP_DJNZB: begin
                  cnt_b_in = cnt_b_dec;
                  pc_in    = (cnt_b_dec != 9'd0) ? lo : pc_next;
               end
               OP_CALL: begin
                  ret_in = pc_next;
                  pc_in  = lo;
               end
               OP_JUMP: begin
                  if (lo == pc_ff) begin
                     // jump to self halts the unit
                     arm_tick = 1'b0;
                     en_in    = 1'b0;
                     armed_in = 1'b0;
                     tag_in   = TAG_NONE;
                  end else begin
                     pc_in = (lo == RETURN_TARGET) ? ret_ff : lo;
                  end
               end
               default: begin
                  pc_in = pc_next;
               end
            endcase
         end
         if (arm_tick) begin
            armed_in = 1'b1;
            tag_in   = TAG_NONE;
         end
      end

      res.active          = en_in;
      res.program_counter = pc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b0;
         armed_ff <= 1'b0;
         tag_ff   <= TAG_NONE;
         pc_ff    <= '0;
         ret_ff   <= '0;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
      end else if (commit) begin
         en_ff    <= en_in;
         armed_ff <= armed_in;
         tag_ff   <= tag_in;
         pc_ff    <= pc_in;
         ret_ff   <= ret_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
      end
   end

   assign pc = pc_ff;

endmodule
